>>> rtl/bpq_pkg.sv
// Types, codes and constants shared by the bounded priority queue modules.
// No dependencies.
package bpq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int OCC_W        = 5;

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } req_t;

    typedef struct packed {
        logic signed [31:0]    out_value;
        logic signed [15:0]    out_priority;
        logic        [1:0]     status;
        logic        [OCC_W-1:0] occupancy;
        logic                  is_empty;
        logic                  is_full;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_SCAN_DRAIN,
        S_SHIFT_INIT,
        S_SHIFT,
        S_SHIFT_DRAIN,
        S_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_read;
        logic shift_init;
        logic shift_read;
        logic load_result;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;   // dequeue or peek on a non-empty store
        logic is_deq;
        logic at_last;     // pointer sits on the last held entry
        logic shift_none;  // maximum was the newest entry
        logic out_free;    // output register empty or being drained
    } sts_t;

endpackage

>>> rtl/bpq_ctrl.sv
// Sequencer for the bounded priority queue: scan, compact and result steps.
// Depends on bpq_pkg.
module bpq_ctrl
    import bpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = sts.need_scan ? S_SCAN : S_RESULT;
            end
            S_SCAN:
            begin
                if (sts.at_last)
                begin
                    state_next = S_SCAN_DRAIN;
                end
            end
            S_SCAN_DRAIN:
            begin
                state_next = sts.is_deq ? S_SHIFT_INIT : S_RESULT;
            end
            S_SHIFT_INIT:
            begin
                state_next = sts.shift_none ? S_RESULT : S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sts.at_last)
                begin
                    state_next = S_SHIFT_DRAIN;
                end
            end
            S_SHIFT_DRAIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_DECIDE:      cmd.scan_init   = 1'b1;
            S_SCAN:        cmd.scan_read   = 1'b1;
            S_SCAN_DRAIN:  cmd             = '0;
            S_SHIFT_INIT:  cmd.shift_init  = 1'b1;
            S_SHIFT:       cmd.shift_read  = 1'b1;
            S_SHIFT_DRAIN: cmd             = '0;
            S_RESULT:      cmd.load_result = sts.out_free;
            default:       cmd             = '0;
        endcase
    end

endmodule

>>> rtl/bpq_dp.sv
// Datapath of the bounded priority queue: entry memory, scan pointer,
// running maximum, occupancy and output register. Depends on bpq_pkg.
module bpq_dp
    import bpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    entry_t mem [CAPACITY];

    logic [1:0]       mode_reg;
    entry_t           item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] ptr_reg;
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_pos_reg;
    logic             rd_valid_reg;
    logic             shift_wr_reg;
    logic [IDX_W-1:0] wr_addr_reg;
    entry_t           best_reg;
    logic [IDX_W-1:0] best_pos_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             enq_ok;

    assign enq_ok = (mode_reg == MODE_ENQ) && (count_reg != CAP_CNT);

    // Single write port: compaction moves or the enqueue append.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wr_addr_reg;
        wr_data = rd_data_reg;
        if (shift_wr_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.load_result && enq_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg       <= req.mode;
            item_reg.value <= req.item_value;
            item_reg.prio  <= req.item_priority;
        end
        rd_pos_reg <= ptr_reg[IDX_W-1:0];
        if (cmd.shift_read)
        begin
            wr_addr_reg <= IDX_W'(ptr_reg - CNT_W'(1));
        end
        // Oldest wins ties: only a strictly larger priority replaces.
        if (rd_valid_reg &&
            ((rd_pos_reg == '0) || (rd_data_reg.prio > best_reg.prio)))
        begin
            best_reg     <= rd_data_reg;
            best_pos_reg <= rd_pos_reg;
        end
        if (cmd.load_result)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            shift_wr_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_read;
            shift_wr_reg <= cmd.shift_read;
            if (cmd.scan_init)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.shift_init)
            begin
                ptr_reg <= CNT_W'(best_pos_reg) + CNT_W'(1);
            end
            else if (cmd.scan_read || cmd.shift_read)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (cmd.load_result)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result assembly
    always_comb
    begin
        count_next            = count_reg;
        rsp_next              = '0;
        rsp_next.status       = ST_OK;
        unique case (mode_reg)
            MODE_ENQ:
            begin
                if (enq_ok)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            MODE_DEQ, MODE_PEEK:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.out_value    = best_reg.value;
                    rsp_next.out_priority = best_reg.prio;
                    if (mode_reg == MODE_DEQ)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.occupancy = OCC_W'(count_next);
        rsp_next.is_empty  = (count_next == '0);
        rsp_next.is_full   = (count_next == CAP_CNT);
    end

    assign sts.need_scan  = ((mode_reg == MODE_DEQ) || (mode_reg == MODE_PEEK))
                            && (count_reg != '0);
    assign sts.is_deq     = (mode_reg == MODE_DEQ);
    assign sts.at_last    = (ptr_reg == (count_reg - CNT_W'(1)));
    assign sts.shift_none = ((CNT_W'(best_pos_reg) + CNT_W'(1)) == count_reg);
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/bounded_priority_queue.sv
// Bounded priority queue with extract-max; depends on bpq_pkg, bpq_ctrl, bpq_dp.
// Steps from accept to result valid: enqueue, unused mode and empty/full cases go from
// decide to result; peek adds the scan of the N held entries; dequeue adds a compaction
// step unless the maximum is the newest entry; a waiting result in the output holds the load.
// Throughput: one request at a time, the next accepted in the cycle after the result loads,
// set by the one-entry-per-cycle scan. Reset: async, clears count and control only.
module bounded_priority_queue
    import bpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Command and status between the sequencer and the datapath.
    cmd_t cmd;
    sts_t sts;

    // Sequencer: one request held from accept until its result is
    // loaded into the output register. The output register lets the next
    // request be accepted while the previous result still waits.
    bpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: entries kept in arrival order in a memory with registered
    // read. The scan reads one entry per cycle tracking the running maximum;
    // dequeue then moves each newer entry down one slot, one per cycle.
    bpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> tb/sv/tb_bounded_priority_queue.sv
// Self-checking testbench for bounded_priority_queue: enqueue, extract-max and peek requests
// are checked against a behavioral queue model kept in this file.
// Depends on bpq_pkg and the bounded_priority_queue RTL only.
module tb_bounded_priority_queue
    import bpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = DEF_CAPACITY;
    // The mode encoding leaves one value unused; the block must ignore it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Slowest item is a dequeue on a full store with the maximum at the head;
    // the settling wait covers it even with a receiver stall on top.
    localparam int SETTLE_CYCLES  = 64;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int SEGMENT_ITEMS  = 100;
    localparam int STREAM_ITEMS   = 300;
    localparam int MAX_REPORTS    = 200;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Behavioral copy of the store: entries kept in arrival order.
    logic signed [31:0] model_value [CAPACITY];
    logic signed [15:0] model_prio  [CAPACITY];
    int                 model_count;

    rsp_t expected_responses [$];

    int  mismatch_count;
    int  responses_seen;
    int  cycle_count;

    // Idle controls. The sender side is applied in send_request, the receiver
    // side in its own process below.
    bit  src_idle_en;
    bit  sink_idle_en;
    int  sink_hold_left;
    int  sink_stall_left;

    bounded_priority_queue #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost response ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_bounded_priority_queue: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------

    // Applies one accepted request to the model and returns the response the
    // block must give for it. Extract-max scans from the oldest entry and
    // takes a new best only on a strictly greater priority, so the oldest of
    // equal priorities wins; a dequeue then closes the gap in arrival order.
    function automatic rsp_t predict_response(input req_t r);
        rsp_t o;
        int   best;
        int   i;
        o = '0;
        o.status = ST_OK;
        case (r.mode)
            MODE_ENQ:
            begin
                if (model_count >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    model_value[model_count] = r.item_value;
                    model_prio[model_count]  = r.item_priority;
                    model_count++;
                end
            end
            MODE_DEQ, MODE_PEEK:
            begin
                if (model_count == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    best = 0;
                    for (i = 1; i < model_count; i++)
                        if (model_prio[i] > model_prio[best])
                            best = i;
                    o.out_value    = model_value[best];
                    o.out_priority = model_prio[best];
                    if (r.mode == MODE_DEQ)
                    begin
                        for (i = best; i < model_count - 1; i++)
                        begin
                            model_value[i] = model_value[i + 1];
                            model_prio[i]  = model_prio[i + 1];
                        end
                        model_count--;
                    end
                end
            end
            default:
            begin
                // unused mode: store untouched, flags only
            end
        endcase
        o.occupancy = OCC_W'(model_count);
        o.is_empty  = (model_count == 0);
        o.is_full   = (model_count >= CAPACITY);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] response %0d: %s got %0h expected %0h",
                     $realtime, responses_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_response(input rsp_t got, input rsp_t want);
        if (got.out_value !== want.out_value)
            report_mismatch("out_value", got.out_value, want.out_value);
        if (got.out_priority !== want.out_priority)
            report_mismatch("out_priority", 32'(got.out_priority), 32'(want.out_priority));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
        if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
        if (got.is_full !== want.is_full)
            report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
    endtask

    // Every accepted response is matched against the oldest prediction.
    always @(posedge clk)
    begin : match_responses
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_responses.size() == 0)
                report_mismatch("unexpected response, status", 32'(rsp.status), 32'hx);
            else
            begin
                want = expected_responses.pop_front();
                check_response(rsp, want);
            end
            responses_seen++;
        end
    end

    // Receiver: a long hold-off when a test asks for one, otherwise random
    // stall bursts of random length while sink_idle_en is set.
    always @(posedge clk)
    begin
        if (sink_hold_left > 0)
        begin
            sink_hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (sink_stall_left > 0)
        begin
            sink_stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            sink_stall_left = $urandom_range(1, 9) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request and returns once it is taken, after a random idle pause
    // when src_idle_en is set. Otherwise valid is left high so a following request goes
    // out back to back; anything that is not another send must lower it first.
    task automatic send_request(input req_t r);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        expected_responses.push_back(predict_response(r));
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Sender pauses until every predicted response has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
    endtask

    function automatic req_t make_request(input logic [1:0] m, input logic [31:0] v,
                                          input logic [15:0] p);
        req_t r;
        r.mode          = m;
        r.item_value    = v;
        r.item_priority = p;
        return r;
    endfunction

    // Narrow priorities crowd the store with ties; wide ones hit the extremes.
    function automatic logic [15:0] random_priority(input bit narrow);
        logic signed [15:0] p;
        if (narrow)
        begin
            p = 16'($urandom_range(0, 4));
            p = p - 16'sd2;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       p = 16'sh8000;
                1:       p = 16'sh7fff;
                default: p = 16'($urandom());
            endcase
        end
        return p;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // enq_pct steers fill level: high values walk the store up to full,
    // low values drain it; the rest split between dequeue and peek.
    function automatic req_t random_request(input int enq_pct, input bit narrow);
        logic [1:0] m;
        if ($urandom_range(0, 99) < 3)
            m = MODE_UNUSED;
        else if ($urandom_range(0, 99) < enq_pct)
            m = MODE_ENQ;
        else if ($urandom_range(0, 3) == 0)
            m = MODE_PEEK;
        else
            m = MODE_DEQ;
        return make_request(m, random_value(), random_priority(narrow));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Dequeue and peek on an empty store report empty; the unused mode is ignored.
    task automatic test_empty_store();
        send_request(make_request(MODE_PEEK, 32'h1234_5678, 16'h0001));
        send_request(make_request(MODE_DEQ, 32'hdead_beef, 16'h7fff));
        send_request(make_request(MODE_UNUSED, 32'hffff_ffff, 16'hffff));
        wait_drained();
    endtask

    // Extreme values and priorities, oldest-wins on a tie, removal from the
    // middle and from the newest position, then drain to empty.
    task automatic test_priority_order();
        send_request(make_request(MODE_ENQ, 32'h7fff_ffff, 16'h7fff));
        send_request(make_request(MODE_ENQ, 32'h8000_0000, 16'h8000));
        send_request(make_request(MODE_ENQ, 32'h0000_0000, 16'h0000));
        send_request(make_request(MODE_ENQ, 32'hffff_ffff, 16'h7fff));   // ties the head
        send_request(make_request(MODE_ENQ, 32'h0000_0001, 16'hffff));
        send_request(make_request(MODE_PEEK, 32'h0, 16'h0));             // head, not its twin
        send_request(make_request(MODE_DEQ, 32'h0, 16'h0));
        send_request(make_request(MODE_DEQ, 32'h0, 16'h0));               // twin, mid-store
        send_request(make_request(MODE_UNUSED, 32'haaaa_5555, 16'h5aa5));
        send_request(make_request(MODE_DEQ, 32'h0, 16'h0));
        send_request(make_request(MODE_ENQ, 32'h0000_0005, 16'h0003));
        send_request(make_request(MODE_ENQ, 32'h0000_0006, 16'h0009));
        send_request(make_request(MODE_DEQ, 32'h0, 16'h0));               // newest is the max
        send_request(make_request(MODE_DEQ, 32'h0, 16'h0));
        send_request(make_request(MODE_DEQ, 32'h0, 16'h0));
        send_request(make_request(MODE_DEQ, 32'h0, 16'h0));               // lowest priority last
        send_request(make_request(MODE_DEQ, 32'h0, 16'h0));               // empty again
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps pushing enqueues, so the
    // block backs up and stalls its input; the store then reaches full and
    // the extra enqueues report full. The store is drained afterwards.
    task automatic test_backpressure_fill();
        int i;
        src_idle_en    = 1'b0;
        sink_idle_en   = 1'b0;
        sink_hold_left = LONG_HOLD;
        for (i = 0; i < CAPACITY + 2; i++)
            send_request(make_request(MODE_ENQ, random_value(), random_priority(i[0])));
        send_request(make_request(MODE_UNUSED, random_value(), random_priority(1'b0)));
        send_request(make_request(MODE_PEEK, random_value(), random_priority(1'b0)));
        wait_drained();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        for (i = 0; i < CAPACITY + 1; i++)
            send_request(make_request(MODE_DEQ, random_value(), random_priority(1'b0)));
        wait_drained();
    endtask

    // Segments with their own fill bias, priority spread and idling; in about a
    // quarter of segments each side runs with no idling, both sides in one in sixteen.
    task automatic test_random_traffic();
        int   counted;
        int   in_segment;
        int   enq_pct;
        bit   narrow;
        req_t r;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 75;
                1:       enq_pct = 50;
                default: enq_pct = 25;
            endcase
            narrow       = $urandom_range(0, 1);
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            in_segment   = 0;
            while (in_segment < SEGMENT_ITEMS && counted < RANDOM_ITEMS)
            begin
                r = random_request(enq_pct, narrow);
                send_request(r);
                if (r.mode != MODE_UNUSED)
                begin
                    counted++;
                    in_segment++;
                end
            end
        end
        wait_drained();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_streaming_no_idle();
        int   counted;
        req_t r;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        counted      = 0;
        while (counted < STREAM_ITEMS)
        begin
            r = random_request((counted < STREAM_ITEMS / 2) ? 60 : 40, counted[5]);
            send_request(r);
            if (r.mode != MODE_UNUSED)
                counted++;
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        rsp_ready       = 1'b0;
        src_idle_en     = 1'b1;
        sink_idle_en    = 1'b1;
        sink_hold_left  = 0;
        sink_stall_left = 0;
        model_count     = 0;
        mismatch_count  = 0;
        responses_seen  = 0;
        cycle_count     = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_priority_order();
        test_backpressure_fill();
        test_random_traffic();
        test_streaming_no_idle();

        // Anything that shows up now has no prediction and counts as a failure.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_bounded_priority_queue: PASS");
        else
            $display("tb_bounded_priority_queue: FAIL");
        $finish;
    end

endmodule
